// ===== rtl/core/tws_pkg.sv =====
// Package for the three-wire serial byte master.
// Holds phase and function codes, field widths and the state/result structs.
// No dependencies.
package tws_pkg;

  localparam int BITS_PER_BYTE = 8;

  localparam int SETUP_W = 10;
  localparam int HIGH_W  = 8;
  localparam int TURN_W  = 10;
  localparam int TICK_W  = 10;
  localparam int CFG_W   = 10;

  localparam logic [1:0] CFG_SETUP = 2'd0;
  localparam logic [1:0] CFG_HIGH  = 2'd1;
  localparam logic [1:0] CFG_TURN  = 2'd2;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_POST = 3'd3;
  localparam logic [2:0] PH_TURN = 3'd4;

  typedef struct packed {
    logic [2:0]        phase;
    logic [3:0]        bit_count;
    logic [TICK_W-1:0] tick_count;
    logic [7:0]        shift_out;
    logic [7:0]        pending_data;
    logic              is_read;
    logic [7:0]        shift_in;
  } state_t;

  typedef struct packed {
    logic       rejected;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       data_pin_drive;
    logic       data_pin_out;
    logic       serial_clock;
    logic       chip_enable;
  } result_t;

  typedef struct packed {
    logic [SETUP_W-1:0] setup_ticks;
    logic [HIGH_W-1:0]  high_ticks;
    logic [TURN_W-1:0]  turnaround_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/three_wire_serial_byte_master.sv =====
// Top level of the three-wire serial byte master.
// Depends on tws_pkg, tws_step and tws_outbuf.
//
// Usage: each slave-side transaction is one time tick (tuser = 0 or 3) or a
// start command (tuser = 1 write, 2 read). Commands are taken only while the
// bus is idle; a command during a transfer is reported as rejected and counts
// as a tick. Every accepted item yields exactly one master-side transaction
// carrying the pin levels and status after that tick, plus the read byte.
// The result is written into the result buffer when the item is accepted.
// Throughput: one item per cycle while the result buffer has room; the sequencer
// steps once per item through a single level of next-state logic into the state register.
// A two-entry result buffer keeps s_tready high while one result waits;
// s_tready drops only when both entries are held by a stalled receiver.
// Reset: sequencer idle, all counters and shift registers cleared, buffer empty, timing
// registers back to setup 5, high 1, turnaround 8. Timing registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while idle, unchecked by the block.
module three_wire_serial_byte_master
  import tws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,  // command_byte[7:0], write_byte[15:8], data_pin_in[16]
  input  logic [1:0]       s_tuser,  // func[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,  // chip_enable, serial_clock, data_pin_out,
                                     // data_pin_drive, busy_res, done_res,
                                     // read_byte[13:6], rejected[14]
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    accept;
  logic    has_room;

  assign s_tready = has_room;
  assign accept   = s_tvalid && has_room;

  tws_step u_step (
    .cur          (st),
    .cfg          (cfg),
    .func         (s_tuser),
    .command_byte (s_tdata[7:0]),
    .write_byte   (s_tdata[15:8]),
    .data_pin_in  (s_tdata[16]),
    .nxt          (st_next),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst)
      st <= '0;
    else if (accept)
      st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks      <= SETUP_W'(5);
      cfg.high_ticks       <= HIGH_W'(1);
      cfg.turnaround_ticks <= TURN_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETUP: cfg.setup_ticks      <= cfg_data[SETUP_W-1:0];
        CFG_HIGH:  cfg.high_ticks       <= cfg_data[HIGH_W-1:0];
        CFG_TURN:  cfg.turnaround_ticks <= cfg_data[TURN_W-1:0];
        default:   ;
      endcase
    end
  end

  tws_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {1'b0, out_res};

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (st.bit_count == '0 && st.tick_count == '0))
    else $error("idle sequencer holds stale counters");

  a_start_enters_pre: assert property (@(posedge clk) disable iff (rst)
    (accept && st.phase == PH_IDLE && (s_tuser == FUNC_WRITE || s_tuser == FUNC_READ))
      |=> (st.phase == PH_PRE))
    else $error("start command did not begin a transfer");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    st.phase <= PH_TURN)
    else $error("sequencer phase out of range");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(st))
    else $error("sequencer advanced while result buffer full");

endmodule

// ===== rtl/core/tws_step.sv =====
// Next-state and pin logic for one tick or command of the serial master.
// Purely combinational; depends on tws_pkg.
module tws_step
  import tws_pkg::*;
(
  input  state_t     cur,
  input  cfg_t       cfg,
  input  logic [1:0] func,
  input  logic [7:0] command_byte,
  input  logic [7:0] write_byte,
  input  logic       data_pin_in,
  output state_t     nxt,
  output result_t    res
);

  logic              start;
  logic [TICK_W-1:0] lim;
  logic [TICK_W-1:0] lim_eff;
  logic              hit;
  logic [TICK_W-1:0] tick_inc;
  logic [3:0]        bc_inc;
  logic              in_read_byte;
  logic              drive;

  always_comb begin
    case (cur.phase)
      PH_HIGH: lim = TICK_W'(cfg.high_ticks);
      PH_TURN: lim = cfg.turnaround_ticks;
      default: lim = cfg.setup_ticks;
    endcase
    lim_eff  = (lim == '0) ? TICK_W'(1) : lim;
    hit      = ({1'b0, cur.tick_count} + (TICK_W+1)'(1)) >= {1'b0, lim_eff};
    tick_inc = cur.tick_count + TICK_W'(1);
    bc_inc   = cur.bit_count + 4'd1;
  end

  always_comb begin
    start = (func == FUNC_WRITE) || (func == FUNC_READ);
    nxt = cur;
    res = '0;
    if (cur.phase == PH_IDLE) begin
      if (start) begin
        nxt.is_read      = (func == FUNC_READ);
        nxt.shift_out    = (func == FUNC_READ) ? (command_byte | 8'h01)
                                               : (command_byte & 8'hFE);
        nxt.pending_data = write_byte;
        nxt.bit_count    = '0;
        nxt.tick_count   = '0;
        nxt.phase        = PH_PRE;
      end
    end else begin
      res.rejected = start;
      case (cur.phase)
        PH_PRE: begin
          if (cur.is_read && (cur.bit_count >= 4'(BITS_PER_BYTE)) && (cur.tick_count == '0))
            nxt.shift_in = {data_pin_in, cur.shift_in[7:1]};
          if (hit) begin
            nxt.tick_count = '0;
            nxt.phase      = PH_HIGH;
          end else begin
            nxt.tick_count = tick_inc;
          end
        end
        PH_HIGH: begin
          if (hit) begin
            nxt.tick_count = '0;
            nxt.phase      = PH_POST;
          end else begin
            nxt.tick_count = tick_inc;
          end
        end
        PH_POST: begin
          if (hit) begin
            nxt.tick_count = '0;
            nxt.bit_count  = bc_inc;
            if (bc_inc == 4'd0) begin
              nxt.phase     = PH_IDLE;
              nxt.bit_count = '0;
            end else if (bc_inc == 4'(BITS_PER_BYTE)) begin
              if (cur.is_read) begin
                nxt.phase = (cfg.turnaround_ticks == '0) ? PH_PRE : PH_TURN;
              end else begin
                nxt.shift_out = cur.pending_data;
                nxt.phase     = PH_PRE;
              end
            end else begin
              nxt.shift_out = {1'b0, cur.shift_out[7:1]};
              nxt.phase     = PH_PRE;
            end
          end else begin
            nxt.tick_count = tick_inc;
          end
        end
        PH_TURN: begin
          if (hit) begin
            nxt.tick_count = '0;
            nxt.phase      = PH_PRE;
          end else begin
            nxt.tick_count = tick_inc;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase
      res.done_res = (nxt.phase == PH_IDLE);
    end

    in_read_byte       = nxt.is_read && (nxt.bit_count >= 4'(BITS_PER_BYTE));
    res.chip_enable    = (nxt.phase != PH_IDLE);
    res.busy_res       = res.chip_enable;
    drive              = res.chip_enable && (nxt.phase != PH_TURN) && !in_read_byte;
    res.data_pin_drive = drive;
    res.data_pin_out   = drive & nxt.shift_out[0];
    res.serial_clock   = (nxt.phase == PH_HIGH);
    res.read_byte      = nxt.shift_in;
  end

endmodule

// ===== rtl/core/tws_outbuf.sv =====
// Two-entry result buffer between the sequencer and the master-side stream.
// Depends on tws_pkg for the result struct.
module tws_outbuf
  import tws_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== tb/sv/three_wire_serial_byte_master_tb.sv =====
// Self-checking testbench for three_wire_serial_byte_master: drives ticks and
// write/read commands, models the bus sequencer and checks every pin result.
// Depends on tws_pkg and the three_wire_serial_byte_master RTL.
module three_wire_serial_byte_master_tb;
  import tws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0] fn;
    logic [7:0] cmd;
    logic [7:0] wdat;
    logic       pin;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  three_wire_serial_byte_master u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer model state and timing registers
  logic [2:0] seq_phase = PH_IDLE;
  logic [3:0] bit_idx = '0;
  logic [9:0] tick_cnt = '0;
  logic [7:0] tx_shift = '0;
  logic [7:0] tx_pending = '0;
  logic       rd_mode = 1'b0;
  logic [7:0] rx_shift = '0;
  logic [9:0] setup_len = 10'd5;
  logic [7:0] high_len = 8'd1;
  logic [9:0] turn_len = 10'd8;

  bus_item_t bus_cmd_q[$];
  result_t pin_state_q[$];
  bus_item_t drv_item;
  int busy_left = 0;
  int err_cnt = 0;
  int stall_cnt = 0;
  logic calm = 1'b0;

  function automatic logic count_out(input int unsigned lim);
    if (lim == 0) lim = 1;
    if (int'(tick_cnt) + 1 >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt + 10'd1;
    return 1'b0;
  endfunction

  function automatic void next_bit();
    bit_idx = bit_idx + 4'd1;
    tick_cnt = '0;
    if (bit_idx == 4'd0) begin
      seq_phase = PH_IDLE;
    end else if (bit_idx == BITS_PER_BYTE) begin
      if (rd_mode) begin
        seq_phase = (turn_len == 0) ? PH_PRE : PH_TURN;
      end else begin
        tx_shift = tx_pending;
        seq_phase = PH_PRE;
      end
    end else begin
      tx_shift = tx_shift >> 1;
      seq_phase = PH_PRE;
    end
  endfunction

  // returns 1 when a read bit is due for sampling
  function automatic logic advance_seq();
    logic smp;
    smp = 1'b0;
    case (seq_phase)
      PH_PRE: begin
        if (rd_mode && bit_idx >= BITS_PER_BYTE && tick_cnt == 0) smp = 1'b1;
        else if (count_out(setup_len)) seq_phase = PH_HIGH;
      end
      PH_HIGH: if (count_out(high_len)) seq_phase = PH_POST;
      PH_POST: if (count_out(setup_len)) next_bit();
      PH_TURN: if (count_out(turn_len)) seq_phase = PH_PRE;
      default: seq_phase = PH_IDLE;
    endcase
    return smp;
  endfunction

  function automatic result_t step_bus(input bus_item_t it);
    result_t r;
    logic start;
    r = '0;
    start = (it.fn == FUNC_WRITE) || (it.fn == FUNC_READ);
    if (seq_phase == PH_IDLE) begin
      if (start) begin
        rd_mode = (it.fn == FUNC_READ);
        tx_shift = {it.cmd[7:1], rd_mode};
        tx_pending = it.wdat;
        bit_idx = '0;
        tick_cnt = '0;
        seq_phase = PH_PRE;
      end
    end else begin
      r.rejected = start;
      if (advance_seq()) begin
        rx_shift = {it.pin, rx_shift[7:1]};
        if (count_out(setup_len)) seq_phase = PH_HIGH;
      end
      r.done_res = (seq_phase == PH_IDLE);
    end
    r.chip_enable = (seq_phase != PH_IDLE);
    r.busy_res = r.chip_enable;
    r.serial_clock = (seq_phase == PH_HIGH);
    r.data_pin_drive = r.chip_enable && seq_phase != PH_TURN
                       && !(rd_mode && bit_idx >= BITS_PER_BYTE);
    r.data_pin_out = r.data_pin_drive & tx_shift[0];
    r.read_byte = rx_shift;
    return r;
  endfunction

  function automatic void check_field(input string nm, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, seen);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pin_state_q.push_back(step_bus(drv_item));
      if (!s_tvalid || s_tready) begin
        if (bus_cmd_q.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          drv_item = bus_cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'b0, drv_item.pin, drv_item.wdat, drv_item.cmd};
          s_tuser <= drv_item.fn;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[14:0]);
        if (pin_state_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          err_cnt++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("chip_enable", want.chip_enable, got.chip_enable);
          check_field("serial_clock", want.serial_clock, got.serial_clock);
          check_field("data_pin_out", want.data_pin_out, got.data_pin_out);
          check_field("data_pin_drive", want.data_pin_drive, got.data_pin_drive);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("rejected", want.rejected, got.rejected);
        end
      end
      m_tready <= calm || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("three_wire_serial_byte_master_tb: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic int txn_len(input logic rd);
    int s, h;
    s = (setup_len == 0) ? 1 : int'(setup_len);
    h = (high_len == 0) ? 1 : int'(high_len);
    return 2 * BITS_PER_BYTE * (2 * s + h) + (rd ? int'(turn_len) : 0);
  endfunction

  // track how many more items keep the bus busy
  task automatic queue_item(input bus_item_t it);
    if (busy_left > 0) busy_left--;
    else if (it.fn == FUNC_WRITE || it.fn == FUNC_READ) busy_left = txn_len(it.fn == FUNC_READ);
    bus_cmd_q.push_back(it);
  endtask

  task automatic push_random();
    bus_item_t it;
    it.cmd = 8'($urandom);
    it.wdat = 8'($urandom);
    it.pin = 1'($urandom);
    if (busy_left > 0 ? $urandom_range(99) < 4 : $urandom_range(99) < 70)
      it.fn = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
    else
      it.fn = ($urandom_range(9) == 0) ? FUNC_NOP : FUNC_TICK;
    queue_item(it);
  endtask

  task automatic finish_txn();
    bus_item_t it;
    while (busy_left > 0) begin
      it.fn = FUNC_TICK;
      it.cmd = 8'($urandom);
      it.wdat = 8'($urandom);
      it.pin = 1'($urandom);
      queue_item(it);
    end
  endtask

  // one transaction with a fixed data pin (2 = random) and commands
  // thrown in halfway
  task automatic directed_txn(input logic [1:0] fn, input logic [7:0] cmd,
                              input logic [7:0] wdat, input int pin_mode);
    bus_item_t it;
    int n;
    it.fn = fn;
    it.cmd = cmd;
    it.wdat = wdat;
    it.pin = 1'b0;
    queue_item(it);
    n = busy_left;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) it.fn = FUNC_READ;
      else if (i == n / 2 + 1) it.fn = FUNC_WRITE;
      else if (i == n / 2 + 2) it.fn = FUNC_NOP;
      else it.fn = FUNC_TICK;
      it.pin = (pin_mode > 1) ? 1'($urandom) : 1'(pin_mode);
      queue_item(it);
    end
  endtask

  task automatic settle();
    while (bus_cmd_q.size() != 0 || pin_state_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      CFG_SETUP: setup_len = 10'(val);
      CFG_HIGH:  high_len = 8'(val);
      default:   turn_len = 10'(val);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned setup_v, input int unsigned high_v,
                              input int unsigned turn_v, input int count);
    settle();
    write_cfg(CFG_SETUP, setup_v);
    write_cfg(CFG_HIGH, high_v);
    write_cfg(CFG_TURN, turn_v);
    repeat (count) push_random();
    finish_txn();
  endtask

  initial begin
    bus_item_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, then a read at the reset timing
    it = '{fn: FUNC_TICK, cmd: 8'hFF, wdat: 8'hFF, pin: 1'b1};
    queue_item(it);
    it.fn = FUNC_NOP;
    queue_item(it);
    directed_txn(FUNC_READ, 8'h00, 8'hFF, 2);

    // zero timing registers
    settle();
    write_cfg(CFG_SETUP, 0);
    write_cfg(CFG_HIGH, 0);
    write_cfg(CFG_TURN, 0);
    directed_txn(FUNC_WRITE, 8'h00, 8'hFF, 1);
    directed_txn(FUNC_READ, 8'hA5, 8'h00, 2);
    settle();
    calm = 1'b1;
    repeat (50) push_random();
    finish_txn();
    settle();
    calm = 1'b0;

    random_phase(1, 2, 3, 40);

    settle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("three_wire_serial_byte_master_tb: PASS");
    end else begin
      $display("three_wire_serial_byte_master_tb: FAIL");
    end
    $finish;
  end

endmodule
